/* src/bcfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcfd_pkg
// Shared types, widths and constants of the bit-crushed feedback delay.
// ----------------------------------------------------------------------------
package bcfd_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int CHANNELS    = 2;
    localparam int CH_BITS     = 1;
    localparam int POS_BITS    = 16;
    localparam int MAX_DELAY   = 1 << POS_BITS;
    localparam int ADDR_BITS   = CH_BITS + POS_BITS;
    localparam int MEM_DEPTH   = CHANNELS * MAX_DELAY;
    localparam int DELAY_W     = 16;
    localparam int CRUSH_W     = 5;
    localparam int GAIN_W      = 17;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int QUANT_W     = SAMPLE_BITS + 1;
    localparam int PROD_W      = SAMPLE_BITS + GAIN_W + 1;
    localparam int SAT_IN_W    = PROD_W + 1;

    localparam logic [GAIN_W-1:0]  UNITY       = 17'h10000;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd24000;
    localparam logic [CRUSH_W-1:0] CRUSH_RESET = 5'd4;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 17'd32768;
    localparam logic [GAIN_W-1:0]  MIX_RESET   = 17'd32768;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [ADDR_BITS-1:0]          addr_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY = 2'd0,
        REG_CRUSH = 2'd1,
        REG_GAIN  = 2'd2,
        REG_MIX   = 2'd3
    } cfg_index_t;

    function automatic sample_t sat_sample(input logic signed [SAT_IN_W-1:0] v);
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = SAT_IN_W'($signed({1'b0, {(SAMPLE_BITS-1){1'b1}}}));
        lo = -hi - SAT_IN_W'(1);
        if (v > hi)
        begin
            return sample_t'(hi);
        end
        else if (v < lo)
        begin
            return sample_t'(lo);
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

/* src/bcfd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcfd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bcfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/bitcrushed_feedback_delay_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitcrushed_feedback_delay_top
// Per-channel feedback delay with a quantizer on the delayed tap.
// Beats pass the pipeline stages and the output register, one per cycle unless
// output back-pressure stalls; the input holds off while a same-channel
// read hits a slot still to be written by one of the three previous beats.
// Reset clears registers only; a per-channel write position and wrap flag
// make never-written delay slots read as zero, so no clearing pass runs.
// ----------------------------------------------------------------------------
module bitcrushed_feedback_delay_top
    import bcfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_BITS-1:0] s_axis_tdata,   // sample_in
    input  logic [CH_BITS-1:0]    s_axis_tuser,    // channel
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [SAMPLE_BITS-1:0] m_axis_tdata,   // sample_out
    output logic [CH_BITS-1:0]    m_axis_tuser,    // channel_out
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [DELAY_W-1:0]  delay_reg;
    logic [CRUSH_W-1:0]  crush_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [GAIN_W-1:0]   mix_reg;
    logic [GAIN_W-1:0]   gain_next;
    logic [GAIN_W-1:0]   mix_next;

    logic [POS_BITS-1:0] wpos_reg [CHANNELS];
    logic [CHANNELS-1:0] wrapped_reg;

    logic                en;
    logic                accept;
    logic                hazard;
    logic [CH_BITS-1:0]  ch_in;
    logic [POS_BITS-1:0] w_cur;
    logic [POS_BITS-1:0] rd_pos;
    logic                rd_written;
    addr_t               rd_addr;
    addr_t               wr_addr;

    logic                s1_valid_reg;
    logic [CH_BITS-1:0]  s1_ch_reg;
    sample_t             s1_x_reg;
    addr_t               s1_waddr_reg;
    addr_t               s1_raddr_reg;
    logic                s1_written_reg;

    logic [SAMPLE_BITS-1:0]     ram_rdata;
    sample_t                    stored;
    logic [CRUSH_W-1:0]         shift;
    logic signed [QUANT_W-1:0]  stored_ext;
    logic signed [QUANT_W-1:0]  half;
    logic signed [QUANT_W-1:0]  biased;
    logic [QUANT_W-1:0]         qmask;
    logic signed [QUANT_W-1:0]  quant;

    logic                       s2_valid_reg;
    logic [CH_BITS-1:0]         s2_ch_reg;
    sample_t                    s2_x_reg;
    addr_t                      s2_waddr_reg;
    logic signed [QUANT_W-1:0]  s2_q_reg;
    sample_t                    sum;

    logic                       s3_valid_reg;
    logic [CH_BITS-1:0]         s3_ch_reg;
    sample_t                    s3_x_reg;
    addr_t                      s3_waddr_reg;
    sample_t                    s3_sum_reg;
    logic signed [PROD_W-1:0]   p_fb;
    logic signed [PROD_W-1:0]   p_wet;
    logic signed [PROD_W-1:0]   p_dry;

    logic                       s4_valid_reg;
    logic [CH_BITS-1:0]         s4_ch_reg;
    addr_t                      s4_waddr_reg;
    logic signed [PROD_W-1:0]   s4_fb_reg;
    logic signed [PROD_W-1:0]   s4_wet_reg;
    logic signed [PROD_W-1:0]   s4_dry_reg;
    logic signed [SAT_IN_W-1:0] fb_wide;
    logic signed [SAT_IN_W-1:0] mix_wide;
    logic signed [SAT_IN_W-1:0] fb_shift;
    logic signed [SAT_IN_W-1:0] mix_shift;
    sample_t                    fb;
    sample_t                    mix;

    logic                       m_valid_reg;
    logic [CH_BITS-1:0]         m_ch_reg;
    sample_t                    m_sample_reg;
    logic                       fwd_valid_reg;
    addr_t                      fwd_addr_reg;
    sample_t                    fwd_data_reg;

    // Configuration
    assign cfg_ready = 1'b1;
    assign gain_next = (cfg_data > UNITY) ? UNITY : cfg_data;
    assign mix_next  = (cfg_data > UNITY) ? UNITY : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RESET;
            crush_reg <= CRUSH_RESET;
            gain_reg  <= GAIN_RESET;
            mix_reg   <= MIX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_DELAY: delay_reg <= cfg_data[DELAY_W-1:0];
                REG_CRUSH: crush_reg <= cfg_data[CRUSH_W-1:0];
                REG_GAIN:  gain_reg  <= gain_next;
                REG_MIX:   mix_reg   <= mix_next;
            endcase
        end
    end

    // Issue stage: address generation, hazard check, read
    assign en      = !s4_valid_reg || !m_valid_reg || m_axis_tready;
    assign ch_in   = s_axis_tuser;
    assign w_cur   = wpos_reg[ch_in];
    assign rd_pos  = w_cur - delay_reg;
    assign rd_written = wrapped_reg[ch_in] || (rd_pos < w_cur);
    assign rd_addr = {ch_in, rd_pos};
    assign wr_addr = {ch_in, w_cur};

    assign hazard = (s1_valid_reg && (s1_waddr_reg == rd_addr))
                 || (s2_valid_reg && (s2_waddr_reg == rd_addr))
                 || (s3_valid_reg && (s3_waddr_reg == rd_addr));

    assign s_axis_tready = en && !hazard;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                wpos_reg[i] <= '0;
            end
            wrapped_reg <= '0;
        end
        else if (accept)
        begin
            wpos_reg[ch_in] <= w_cur + POS_BITS'(1);
            if (&w_cur)
            begin
                wrapped_reg[ch_in] <= 1'b1;
            end
        end
    end

    bcfd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (en && s4_valid_reg),
        .waddr (s4_waddr_reg),
        .wdata (fb),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Stage 1: read data, forward, quantize
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ch_reg      <= ch_in;
            s1_x_reg       <= sample_t'(s_axis_tdata);
            s1_waddr_reg   <= wr_addr;
            s1_raddr_reg   <= rd_addr;
            s1_written_reg <= rd_written;
        end
    end

    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_raddr_reg))
        begin
            stored = fwd_data_reg;
        end
        else if (s1_written_reg)
        begin
            stored = sample_t'(ram_rdata);
        end
        else
        begin
            stored = '0;
        end
        stored_ext = QUANT_W'(stored);
        shift      = CRUSH_W'(FRAC_BITS) - crush_reg;
        half       = QUANT_W'(1) << (shift - CRUSH_W'(1));
        biased     = stored_ext + half - QUANT_W'(stored[SAMPLE_BITS-1]);
        qmask      = {QUANT_W{1'b1}} << shift;
        if (crush_reg >= CRUSH_W'(FRAC_BITS))
        begin
            quant = stored_ext;
        end
        else
        begin
            quant = biased & $signed(qmask);
        end
    end

    // Stage 2: saturating add
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_ch_reg    <= s1_ch_reg;
            s2_x_reg     <= s1_x_reg;
            s2_waddr_reg <= s1_waddr_reg;
            s2_q_reg     <= quant;
        end
    end

    assign sum = sat_sample(SAT_IN_W'(s2_x_reg) + SAT_IN_W'(s2_q_reg));

    // Stage 3: products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_ch_reg    <= s2_ch_reg;
            s3_x_reg     <= s2_x_reg;
            s3_waddr_reg <= s2_waddr_reg;
            s3_sum_reg   <= sum;
        end
    end

    assign p_fb  = s3_sum_reg * $signed({1'b0, gain_reg});
    assign p_wet = s3_sum_reg * $signed({1'b0, mix_reg});
    assign p_dry = s3_x_reg * $signed({1'b0, UNITY - mix_reg});

    // Stage 4: round, saturate, write back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_ch_reg    <= s3_ch_reg;
            s4_waddr_reg <= s3_waddr_reg;
            s4_fb_reg    <= p_fb;
            s4_wet_reg   <= p_wet;
            s4_dry_reg   <= p_dry;
        end
    end

    always_comb
    begin
        fb_wide   = SAT_IN_W'(s4_fb_reg);
        mix_wide  = SAT_IN_W'(s4_wet_reg) + SAT_IN_W'(s4_dry_reg);
        fb_shift  = $signed(fb_wide + SAT_IN_W'(17'sd32768)
                            - SAT_IN_W'(fb_wide[SAT_IN_W-1])) >>> 16;
        mix_shift = $signed(mix_wide + SAT_IN_W'(17'sd32768)
                            - SAT_IN_W'(mix_wide[SAT_IN_W-1])) >>> 16;
        fb        = sat_sample(fb_shift);
        mix       = sat_sample(mix_shift);
    end

    // Output register and write-forward register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (en && s4_valid_reg)
            begin
                m_valid_reg <= 1'b1;
            end
            if (en)
            begin
                fwd_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && s4_valid_reg)
        begin
            m_ch_reg     <= s4_ch_reg;
            m_sample_reg <= mix;
        end
        if (en)
        begin
            fwd_addr_reg <= s4_waddr_reg;
            fwd_data_reg <= fb;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_sample_reg;
    assign m_axis_tuser  = m_ch_reg;

endmodule
